@@ sv/sha256_message_hasher_unit_macros.svh @@
// assertion helpers shared by the hasher modules
// all of them sample on clk_i and stay quiet while rst_ni is low
`ifndef SHA256_MESSAGE_HASHER_UNIT_MACROS_SVH
`define SHA256_MESSAGE_HASHER_UNIT_MACROS_SVH

// same-cycle implication
`define SHA256MH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA256MH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sha256mh_pkg.sv @@
package sha256mh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  // command bundle from the sequencer to the compression core
  typedef struct packed {
    logic       push;   // shift one byte into the block window
    logic [7:0] data;
    logic       start;  // begin the 64 rounds on the window
    logic       init;   // load the initial hash value
  } core_cmd_t;

  localparam int unsigned ROUNDS = 64;
  localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;

  // initial hash value, word 0 in the lowest slot
  localparam hash_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // round constants
  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ sv/sha256_message_hasher_unit.sv @@
// sha-256 over a byte stream, one byte beat per cycle while filling a block
// a 64th byte stalls input through 64 rounds in the shared round unit and then the fold
// message end: pad bytes at one per cycle to each block end, 9 to 64 of them in the block
// that takes the length and 1 to 8 in a block before it, with a compression after each
// padded block, then eight digest beats, word 0 first
// reset (async, active low) loads the initial hash and clears fill and length counts
`include "sha256_message_hasher_unit_macros.svh"

module sha256_message_hasher_unit import sha256mh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_e;

  top_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] count_q, count_d;
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        final_q, final_d;
  logic [2:0]  idx_q, idx_d;
  logic        in_acc, out_acc;
  logic [63:0] bit_len;
  logic [7:0]  len_byte, pad_byte;
  core_cmd_t   cmd;
  logic        core_done;
  hash_t       hash;

  sha256mh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .done_o (core_done),
    .hash_o (hash)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = hash[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == 3'd7);

  // padding byte: marker, zeros, then big-endian bit length in the tail
  always_comb begin
    bit_len  = {count_q, 3'b000};
    len_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
    if (first_q) begin
      pad_byte = PAD_MARK;
    end else if (final_q && fill_q >= LEN_START) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // message sequencer
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    count_d = count_q;
    pad_d   = pad_q;
    first_d = first_q;
    final_d = final_q;
    idx_d   = idx_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            cmd.push = 1'b1;
            cmd.data = s_axis_tdata;
            fill_d   = fill_q + 6'd1;
            count_d  = count_q + 61'd1;
          end
          if (s_axis_tlast) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
            state_d = S_PAD;
          end
          if (s_axis_tuser && fill_q == FILL_LAST) begin
            cmd.start = 1'b1;
            state_d   = S_COMP;
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        cmd.data = pad_byte;
        fill_d   = fill_q + 6'd1;
        first_d  = 1'b0;
        if (first_q) begin
          final_d = (fill_q < LEN_START);
        end
        if (fill_q == FILL_LAST) begin
          cmd.start = 1'b1;
          state_d   = S_COMP;
        end
      end
      S_COMP: begin
        if (core_done) begin
          if (!pad_q) begin
            state_d = S_IDLE;
          end else if (first_q) begin
            state_d = S_PAD;
          end else if (final_q) begin
            state_d = S_OUT;
          end else begin
            final_d = 1'b1;
            state_d = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd.init = 1'b1;
            fill_d   = '0;
            count_d  = '0;
            pad_d    = 1'b0;
            final_d  = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      count_q <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      final_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      final_q <= final_d;
      idx_q   <= idx_d;
    end
  end

  `SHA256MH_ASSERT_IMP(a_one_side, 1'b1, !(s_axis_tready && m_axis_tvalid),
                       "input and output open together")
  `SHA256MH_ASSERT_IMP(a_done_in_comp, core_done, state_q == S_COMP,
                       "compression finished outside wait state")
  `SHA256MH_ASSERT_IMP(a_out_aligned, state_q == S_OUT, fill_q == 6'd0 && pad_q,
                       "digest beats with partial block")
  `SHA256MH_ASSERT_NXT(a_restart, out_acc && m_axis_tlast,
                       state_q == S_IDLE && count_q == 61'd0, "no restart after digest")

endmodule

@@ sv/sha256mh_core.sv @@
`include "sha256_message_hasher_unit_macros.svh"

module sha256mh_core import sha256mh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_cmd_t cmd_i,
  output logic      done_o,
  output hash_t     hash_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_e;

  core_state_e state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  hash_t       hash_q, hash_d;
  hash_t       v_q, v_d;
  word_t       w_q [16];
  word_t       w_d [16];
  word_t       t1, t2, w_new;

  // round datapath and schedule expansion over the sliding window
  always_comb begin
    w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
    t1 = v_q[7] + bsig1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6]) + K_TAB[rnd_q] + w_q[0];
    t2 = bsig0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
  end

  // sequencer: load, 64 rounds, then fold into the hash
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    hash_d  = hash_q;
    v_d     = v_q;
    w_d     = w_q;
    unique case (state_q)
      C_IDLE: begin
        if (cmd_i.push) begin
          for (int i = 0; i < 15; i++) begin
            w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
          end
          w_d[15] = {w_q[15][23:0], cmd_i.data};
        end
        if (cmd_i.init) begin
          hash_d = HASH_IV;
        end
        if (cmd_i.start) begin
          state_d = C_ROUND;
          rnd_d   = '0;
          v_d     = hash_q;
        end
      end
      C_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = w_new;
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  // control and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      hash_q  <= HASH_IV;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      hash_q  <= hash_d;
    end
  end

  // working variables and block window
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  assign done_o = (state_q == C_ADD);
  assign hash_o = hash_q;

  `SHA256MH_ASSERT_IMP(a_start_idle, cmd_i.start, state_q == C_IDLE, "start while busy")
  `SHA256MH_ASSERT_IMP(a_load_idle, cmd_i.push || cmd_i.init, state_q == C_IDLE,
                       "window or hash touched during rounds")
  `SHA256MH_ASSERT_NXT(a_last_round, state_q == C_ROUND && rnd_q == LAST_ROUND,
                       state_q == C_ADD, "round count overrun")

endmodule
